// ===== src/rgb_grad_pkg.sv =====
package rgb_grad_pkg;

  // Field widths
  localparam int COLOR_W = 16;
  localparam int LEN_W   = 7;
  localparam int CH_W    = 6;   // widest channel (green)

  // Default longest run
  localparam int MAX_LENGTH_DEF = 64;

  // Runs shorter than this give only start and end colors
  localparam int SHORTEST = 3;

  // RGB565 layout
  localparam logic [COLOR_W-1:0] RED_MASK   = 16'hf800;
  localparam logic [COLOR_W-1:0] GREEN_MASK = 16'h07e0;
  localparam logic [COLOR_W-1:0] BLUE_MASK  = 16'h001f;
  localparam int RED_SHIFT   = 11;
  localparam int GREEN_SHIFT = 5;

  // Channel select codes
  localparam logic [1:0] CH_RED = 2'd0;
  localparam logic [1:0] CH_GRN = 2'd1;
  localparam logic [1:0] CH_BLU = 2'd2;

  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic [LEN_W-1:0]   length;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } result_t;

  // Pull one channel out of an RGB565 word, zero-extended to CH_W bits
  function automatic logic [CH_W-1:0] get_chan(logic [COLOR_W-1:0] c, logic [1:0] idx);
    logic [COLOR_W-1:0] v;
    begin
      case (idx)
        CH_RED:  v = (c & RED_MASK) >> RED_SHIFT;
        CH_GRN:  v = (c & GREEN_MASK) >> GREEN_SHIFT;
        default: v = c & BLUE_MASK;
      endcase
      return v[CH_W-1:0];
    end
  endfunction

endpackage

// ===== src/rgb565_gradient_generator.sv =====
// Channel  | Dir | Handshake                   | Payload
// item     | in  | item_valid / item_ready     | start_color, end_color, length
// result   | out | result_valid / result_ready | color, last
//
// One item gives length colors (two when length < 3, length capped at MAX_LENGTH).
// Each interpolated color runs one shared restoring divider over red, green, blue,
// in that order, CH_W quotient bits per channel; start and end colors need no division.
// item_ready is high only while the sequencer is idle; a result stalled on result_ready
// holds the sequencer at its next output step. Reset (rst, synchronous) clears state and result_valid.
module rgb565_gradient_generator #(
  parameter int MAX_LENGTH = rgb_grad_pkg::MAX_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  rgb_grad_pkg::item_t   item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output rgb_grad_pkg::result_t result
);
  import rgb_grad_pkg::*;

  localparam int SPAN_W = $clog2(MAX_LENGTH);
  localparam int NUM_W  = CH_W + SPAN_W;
  localparam int BIT_W  = $clog2(CH_W);
  localparam int RES_W  = 3 * CH_W;

  typedef enum logic [2:0] {S_IDLE, S_START, S_DIV, S_PUT, S_FIN} state_t;

  state_t              state;
  logic [COLOR_W-1:0]  start_color;
  logic [COLOR_W-1:0]  end_color;
  logic                short_run;
  logic [SPAN_W-1:0]   span;
  logic [SPAN_W-1:0]   x;
  logic [CH_W-1:0]     sch [3];
  logic [CH_W-1:0]     ech [3];
  logic [NUM_W-1:0]    num [3];
  logic [NUM_W-1:0]    rem;
  logic [RES_W-1:0]    res;
  logic [1:0]          ch;
  logic [BIT_W-1:0]    bit_cnt;

  // Input decode
  logic [LEN_W-1:0]    n_sat;
  logic [SPAN_W-1:0]   span_in;
  logic [SPAN_W-1:0]   span_m1;
  logic                short_in;
  logic [NUM_W-1:0]    num_init [3];
  logic [NUM_W-1:0]    num_step [3];

  always_comb begin
    n_sat    = (item.length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : item.length;
    span_in  = SPAN_W'(n_sat - LEN_W'(1));
    span_m1  = SPAN_W'(span_in - SPAN_W'(1));
    short_in = item.length < LEN_W'(SHORTEST);
    for (int i = 0; i < 3; i++) begin
      // numerator at step 1: s*(span-1) + e
      num_init[i] = NUM_W'(get_chan(item.start_color, 2'(i))) * NUM_W'(span_m1)
                  + NUM_W'(get_chan(item.end_color, 2'(i)));
      // advance one step: add signed (e - s); true value always fits
      num_step[i] = num[i] + NUM_W'(ech[i]) - NUM_W'(sch[i]);
    end
  end

  // Shared divider step
  logic [NUM_W-1:0] dsh;
  logic             ge;
  logic [NUM_W-1:0] rem_sub;
  logic [NUM_W-1:0] num_sel;

  always_comb begin
    dsh     = NUM_W'(span) << bit_cnt;
    ge      = rem >= dsh;
    rem_sub = rem - dsh;
    case (ch)
      CH_RED:  num_sel = num[1];
      CH_GRN:  num_sel = num[2];
      default: num_sel = num[0];
    endcase
  end

  logic out_free;
  logic last_step;
  logic emit;
  assign out_free   = !result_valid || result_ready;
  assign last_step  = (SPAN_W'(x + SPAN_W'(1)) == span);
  assign item_ready = (state == S_IDLE);
  assign emit       = out_free && (state == S_START || state == S_PUT || state == S_FIN);

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // load a new color or retire the transferred one
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            start_color <= item.start_color;
            end_color   <= item.end_color;
            short_run   <= short_in;
            span        <= span_in;
            x           <= SPAN_W'(1);
            for (int i = 0; i < 3; i++) begin
              sch[i] <= get_chan(item.start_color, 2'(i));
              ech[i] <= get_chan(item.end_color, 2'(i));
              num[i] <= num_init[i];
            end
            state <= S_START;
          end
        end
        S_START: begin
          if (out_free) begin
            result.color <= start_color;
            result.last  <= 1'b0;
            if (short_run) begin
              state <= S_FIN;
            end else begin
              rem     <= num[0];
              ch      <= CH_RED;
              bit_cnt <= BIT_W'(CH_W - 1);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          res <= {res[RES_W-2:0], ge};
          if (bit_cnt == '0) begin
            if (ch == CH_BLU) begin
              state <= S_PUT;
            end else begin
              ch      <= ch + 2'd1;
              rem     <= num_sel;
              bit_cnt <= BIT_W'(CH_W - 1);
            end
          end else begin
            if (ge) begin
              rem <= rem_sub;
            end
            bit_cnt <= bit_cnt - BIT_W'(1);
          end
        end
        S_PUT: begin
          if (out_free) begin
            result.color <= {res[2*CH_W+4:2*CH_W], res[2*CH_W-1:CH_W], res[4:0]};
            result.last  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              num[i] <= num_step[i];
            end
            x <= SPAN_W'(x + SPAN_W'(1));
            if (last_step) begin
              state <= S_FIN;
            end else begin
              rem     <= num_step[0];
              ch      <= CH_RED;
              bit_cnt <= BIT_W'(CH_W - 1);
              state   <= S_DIV;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            result.color <= end_color;
            result.last  <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider remainder stays below the divisor at the current bit plus one
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (NUM_W+1)'(rem) < ((NUM_W+1)'(span) << (bit_cnt + BIT_W'(1))))
    else $error("divider remainder out of range");

  // Step counter stays inside the interpolated range
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_PUT) |-> (x != '0 && x < span))
    else $error("step counter out of range");

  // Blue channel done hands over to the output step
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && bit_cnt == '0 && ch == CH_BLU) |=> state == S_PUT)
    else $error("divider did not finish to output");

  // An accepted item starts with the start color step
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> state == S_START)
    else $error("accepted item did not start a run");

endmodule
